/* hw/rtl/fjdg_pkg.sv */
// Shared types, widths and reset constants for the frame jitter drop governor.
// Used by fjdg_meas_pipe and frame_jitter_drop_governor; no dependencies.
`default_nettype none

package fjdg_pkg;

  // Default parameter values
  localparam int TUNE_INTERVAL_DEF = 120;
  localparam int TIME_BITS_DEF     = 40;

  // Field widths
  localparam int INTERVAL_W = 20;
  localparam int ALPHA_W    = 16;
  localparam int LIM_W      = 4;
  localparam int DEV_W      = 24;
  localparam int EMA_W      = 32;   // Q24.8 microseconds
  localparam int FRAC_W     = 8;
  localparam int CODEC_W    = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [DEV_W-1:0] DEV_MAX = {DEV_W{1'b1}};

  // Register reset values
  localparam logic [INTERVAL_W-1:0] RST_INTERVAL   = 20'd16667;
  localparam logic [ALPHA_W-1:0]    RST_ALPHA      = 16'd3277;
  localparam logic [LIM_W-1:0]      RST_INIT_LIMIT = 4'd2;
  localparam logic [LIM_W-1:0]      RST_TUNE_MIN   = 4'd1;
  localparam logic [LIM_W-1:0]      RST_TUNE_MAX   = 4'd4;
  localparam logic [DEV_W-1:0]      RST_HIGH       = 24'd3000;
  localparam logic [DEV_W-1:0]      RST_LOW        = 24'd1000;

  typedef enum logic [CODEC_W-1:0] {
    CODEC_H264    = 2'd0,
    CODEC_H265    = 2'd1,
    CODEC_HDR     = 2'd2,
    CODEC_UNKNOWN = 2'd3
  } codec_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_INTERVAL   = 3'd0,
    REG_ALPHA      = 3'd1,
    REG_INIT_LIMIT = 3'd2,
    REG_TUNE_MIN   = 3'd3,
    REG_TUNE_MAX   = 3'd4,
    REG_HIGH       = 3'd5,
    REG_LOW        = 3'd6,
    REG_CODEC      = 3'd7
  } cfg_idx_t;

  // Per-frame fields that ride along the measurement pipeline
  typedef struct packed {
    logic             key_frame;
    logic             depth_valid;
    logic [LIM_W-1:0] buffer_depth;
    codec_t           codec_report;
  } frame_t;

  // Measurement result handed to the decision stage
  typedef struct packed {
    frame_t           frame;
    logic             have_prev;
    logic [DEV_W-1:0] dev;
    logic [EMA_W-1:0] ema;
  } meas_t;

endpackage

`default_nettype wire

/* hw/rtl/frame_jitter_drop_governor.sv */
// Frame jitter drop governor: drop decision, depth limit tuning, codec tracking.
// Top level; instantiates fjdg_meas_pipe and depends on fjdg_pkg.
//
// Usage:
//   in_*  : one transaction per arriving frame. in_tdata = arrival time
//           [TIME_BITS-1:0], depth_valid, buffer_depth[3:0], codec_report[1:0];
//           in_tuser = keyframe flag.
//   out_* : one transaction per frame, in order. out_tdata = average jitter,
//           window max jitter, depth_limit, codec in use; out_tuser = dropped.
//   cfg_* : register writes (index in cfg_addr), always ready; write only while
//           no frame is in flight. Index 2 also reloads the depth limit, index 7
//           also reloads the codec in use.
// An input transaction reaches out_tvalid through five register stages (delta,
// deviation, dev*alpha product, EMA multiply-add, decision/result), the first
// loaded on the accepting edge. Throughput is one frame per cycle while out_tready
// does not stall the result; the EMA multiply-add closes its own feedback loop.
// Reset loads the register defaults, clears all jitter state and the pipeline;
// the first frame after reset records its arrival time but no jitter sample.
// While out_tready is low the result holds and empty stages behind it still fill;
// in_tready falls only once all five stages are occupied.
`default_nettype none

module frame_jitter_drop_governor #(
  parameter int TUNE_INTERVAL = fjdg_pkg::TUNE_INTERVAL_DEF,
  parameter int TIME_BITS     = fjdg_pkg::TIME_BITS_DEF,
  localparam int IN_W  = ((TIME_BITS + 7 + 7) / 8) * 8,
  localparam int OUT_W = 56
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // time [TIME_BITS-1:0], depth_valid, buffer_depth[3:0], codec_report[1:0], zero pad
  input  wire  [IN_W-1:0]                  in_tdata,
  // keyframe flag
  input  wire                              in_tuser,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // avg jitter[23:0], window max jitter[23:0], depth_limit[3:0], codec in use[1:0], pad
  output logic [OUT_W-1:0]                 out_tdata,
  // dropped
  output logic                             out_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [fjdg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire  [fjdg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int LW    = fjdg_pkg::LIM_W;
  localparam int DW    = fjdg_pkg::DEV_W;
  localparam int EW    = fjdg_pkg::EMA_W;
  localparam int CW    = fjdg_pkg::CODEC_W;
  localparam int CNT_W = $clog2(TUNE_INTERVAL + 1);
  localparam int SUM_W = EW + CNT_W;

  // Configuration registers
  logic [fjdg_pkg::INTERVAL_W-1:0] interval_r;
  logic [fjdg_pkg::ALPHA_W-1:0]    alpha_r;
  logic [LW-1:0]                   tune_min_r;
  logic [LW-1:0]                   tune_max_r;
  logic [DW-1:0]                   high_r;
  logic [DW-1:0]                   low_r;
  fjdg_pkg::codec_t                neg_codec_r;

  // Tuning thresholds, high/low * 256 * TUNE_INTERVAL
  logic [SUM_W-1:0] hi_thr_r, lo_thr_r;

  // Governor state
  logic [LW-1:0]    limit_r, limit_nxt;
  fjdg_pkg::codec_t codec_r, codec_nxt;
  logic [DW-1:0]    wmax_r, wmax_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  // Result register
  logic             out_valid_r;
  logic             out_drop_r;
  logic [DW-1:0]    out_avg_r;
  logic [DW-1:0]    out_max_r;
  logic [LW-1:0]    out_limit_r;
  fjdg_pkg::codec_t out_codec_r;

  fjdg_pkg::frame_t in_frame;
  fjdg_pkg::meas_t  meas;
  logic             meas_valid;
  logic             out_en;
  logic             take;
  logic             drop;
  logic             tune;
  logic             hevc;
  logic [DW-1:0]    wmax_seen;
  fjdg_pkg::codec_t cfg_codec;
  logic             cfg_limit_wr;
  logic             cfg_codec_wr;

  assign in_frame.key_frame    = in_tuser;
  assign in_frame.depth_valid  = in_tdata[TIME_BITS];
  assign in_frame.buffer_depth = in_tdata[TIME_BITS+1 +: LW];
  assign in_frame.codec_report = fjdg_pkg::codec_t'(in_tdata[TIME_BITS+1+LW +: CW]);

  fjdg_meas_pipe #(
    .TIME_BITS (TIME_BITS)
  ) u_meas (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_interval (interval_r),
    .cfg_alpha    (alpha_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_time      (in_tdata[TIME_BITS-1:0]),
    .in_frame     (in_frame),
    .out_valid    (meas_valid),
    .out_ready    (out_en),
    .out_meas     (meas)
  );

  assign out_en    = !out_valid_r || out_tready;
  assign take      = meas_valid && out_en;
  assign cfg_ready = 1'b1;

  // Limit and codec reloads take priority over a frame update
  assign cfg_limit_wr = cfg_valid && (cfg_addr == fjdg_pkg::REG_INIT_LIMIT);
  assign cfg_codec_wr = cfg_valid && (cfg_addr == fjdg_pkg::REG_CODEC);

  // Unused codec code 3 is stored as H.264
  assign cfg_codec = (cfg_data[CW-1:0] == fjdg_pkg::CODEC_UNKNOWN)
                   ? fjdg_pkg::CODEC_H264 : fjdg_pkg::codec_t'(cfg_data[CW-1:0]);

  always_comb begin
    drop = meas.frame.depth_valid && !meas.frame.key_frame
        && (meas.frame.buffer_depth > limit_r);

    wmax_seen = (meas.have_prev && (meas.dev > wmax_r)) ? meas.dev : wmax_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    wmax_nxt  = wmax_seen;
    limit_nxt = limit_r;
    codec_nxt = codec_r;
    tune      = 1'b0;
    hevc      = (neg_codec_r == fjdg_pkg::CODEC_H265)
             || (neg_codec_r == fjdg_pkg::CODEC_HDR);

    if (!drop) begin
      count_nxt = count_r + CNT_W'(1);
      sum_nxt   = sum_r + SUM_W'(meas.ema);
      tune      = (count_nxt == CNT_W'(TUNE_INTERVAL));
      if (tune) begin
        if ((sum_nxt > hi_thr_r) && (limit_r < tune_max_r)) begin
          limit_nxt = limit_r + LW'(1);
        end else if ((sum_nxt < lo_thr_r) && (limit_r > tune_min_r)) begin
          limit_nxt = limit_r - LW'(1);
        end
        wmax_nxt  = '0;
        count_nxt = '0;
        sum_nxt   = '0;
      end
      // HEVC sessions ignore stray H.264 reports
      if ((meas.frame.codec_report != fjdg_pkg::CODEC_UNKNOWN)
          && !(hevc && (meas.frame.codec_report == fjdg_pkg::CODEC_H264))) begin
        codec_nxt = meas.frame.codec_report;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r   <= fjdg_pkg::RST_INTERVAL;
      alpha_r      <= fjdg_pkg::RST_ALPHA;
      tune_min_r   <= fjdg_pkg::RST_TUNE_MIN;
      tune_max_r   <= fjdg_pkg::RST_TUNE_MAX;
      high_r       <= fjdg_pkg::RST_HIGH;
      low_r        <= fjdg_pkg::RST_LOW;
      neg_codec_r  <= fjdg_pkg::CODEC_H264;
      limit_r      <= fjdg_pkg::RST_INIT_LIMIT;
      codec_r      <= fjdg_pkg::CODEC_H264;
      wmax_r       <= '0;
      count_r      <= '0;
      sum_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_en) out_valid_r <= meas_valid;
      if (cfg_limit_wr) begin
        limit_r <= cfg_data[LW-1:0];
      end else if (take) begin
        limit_r <= limit_nxt;
      end
      if (cfg_codec_wr) begin
        codec_r <= cfg_codec;
      end else if (take) begin
        codec_r <= codec_nxt;
      end
      if (take) begin
        wmax_r  <= wmax_nxt;
        count_r <= count_nxt;
        sum_r   <= sum_nxt;
      end
      if (cfg_valid) begin
        case (fjdg_pkg::cfg_idx_t'(cfg_addr))
          fjdg_pkg::REG_INTERVAL:   interval_r <= cfg_data[fjdg_pkg::INTERVAL_W-1:0];
          fjdg_pkg::REG_ALPHA:      alpha_r    <= cfg_data[fjdg_pkg::ALPHA_W-1:0];
          fjdg_pkg::REG_TUNE_MIN:   tune_min_r <= cfg_data[LW-1:0];
          fjdg_pkg::REG_TUNE_MAX:   tune_max_r <= cfg_data[LW-1:0];
          fjdg_pkg::REG_HIGH:       high_r     <= cfg_data[DW-1:0];
          fjdg_pkg::REG_LOW:        low_r      <= cfg_data[DW-1:0];
          fjdg_pkg::REG_CODEC:      neg_codec_r <= cfg_codec;
          default: ;
        endcase
      end
    end
  end

  // Thresholds follow the registers in the next cycle, long before a frame reaches here
  always_ff @(posedge clk) begin
    hi_thr_r <= (SUM_W'(high_r) * SUM_W'(TUNE_INTERVAL)) << fjdg_pkg::FRAC_W;
    lo_thr_r <= (SUM_W'(low_r) * SUM_W'(TUNE_INTERVAL)) << fjdg_pkg::FRAC_W;
    if (take) begin
      out_drop_r  <= drop;
      out_avg_r   <= meas.ema[fjdg_pkg::FRAC_W +: DW];
      out_max_r   <= wmax_nxt;
      out_limit_r <= limit_nxt;
      out_codec_r <= codec_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_drop_r;
  assign out_tdata  = OUT_W'({out_codec_r, out_limit_r, out_max_r, out_avg_r});

endmodule

`default_nettype wire

/* hw/rtl/fjdg_meas_pipe.sv */
// Jitter measurement pipeline: inter-arrival deviation, weighted product, EMA.
// Four elastic stages; depends on fjdg_pkg.
`default_nettype none

module fjdg_meas_pipe #(
  parameter int TIME_BITS = fjdg_pkg::TIME_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire  [fjdg_pkg::INTERVAL_W-1:0]  cfg_interval,
  input  wire  [fjdg_pkg::ALPHA_W-1:0]     cfg_alpha,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [TIME_BITS-1:0]             in_time,
  input  wire  fjdg_pkg::frame_t           in_frame,
  output logic                             out_valid,
  input  wire                              out_ready,
  output fjdg_pkg::meas_t                  out_meas
);

  localparam int IW     = fjdg_pkg::INTERVAL_W;
  localparam int AW     = fjdg_pkg::ALPHA_W;
  localparam int DW     = fjdg_pkg::DEV_W;
  localparam int EW     = fjdg_pkg::EMA_W;
  localparam int PROD_W = DW + AW;
  localparam int ACC_W  = EW + AW + 2;

  logic en1, en2, en3, en4;
  logic v1_r, v2_r, v3_r, v4_r;

  logic                 have_prev_r;
  logic [TIME_BITS-1:0] prev_time_r;

  fjdg_pkg::frame_t     f1_r, f2_r, f3_r, f4_r;
  logic                 hp1_r, hp2_r, hp3_r, hp4_r;
  logic [TIME_BITS-1:0] delta1_r;
  logic [DW-1:0]        dev2_r, dev3_r, dev4_r;
  logic [PROD_W-1:0]    prod3_r;
  logic [EW-1:0]        ema_r;

  logic [TIME_BITS:0]   diff_up;
  logic [IW-1:0]        diff_dn;
  logic [TIME_BITS-1:0] dev_raw;
  logic [DW-1:0]        dev_nxt;
  logic [AW:0]          weight;
  logic [ACC_W-1:0]     acc;
  logic [EW-1:0]        ema_nxt;

  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // |delta - interval|; when delta is below the interval the gap fits the interval width
  always_comb begin
    diff_up = {1'b0, delta1_r} - (TIME_BITS+1)'(cfg_interval);
    diff_dn = cfg_interval - delta1_r[IW-1:0];
    dev_raw = diff_up[TIME_BITS] ? TIME_BITS'(diff_dn) : diff_up[TIME_BITS-1:0];
    dev_nxt = (dev_raw > TIME_BITS'(fjdg_pkg::DEV_MAX)) ? fjdg_pkg::DEV_MAX
                                                         : dev_raw[DW-1:0];
  end

  // EMA with half-up rounding; prod3_r already holds dev*alpha
  always_comb begin
    weight  = (AW+1)'(1 << AW) - (AW+1)'(cfg_alpha);
    acc     = ACC_W'(ema_r) * ACC_W'(weight)
            + ACC_W'({prod3_r, {fjdg_pkg::FRAC_W{1'b0}}})
            + ACC_W'(1 << (AW - 1));
    ema_nxt = acc[AW +: EW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      have_prev_r <= 1'b0;
      prev_time_r <= '0;
      ema_r       <= '0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
        if (in_valid) begin
          have_prev_r <= 1'b1;
          prev_time_r <= in_time;
        end
      end
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) begin
        v4_r <= v3_r;
        if (v3_r && hp3_r) ema_r <= ema_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      f1_r     <= in_frame;
      hp1_r    <= have_prev_r;
      delta1_r <= in_time - prev_time_r;
    end
    if (en2) begin
      f2_r   <= f1_r;
      hp2_r  <= hp1_r;
      dev2_r <= dev_nxt;
    end
    if (en3) begin
      f3_r    <= f2_r;
      hp3_r   <= hp2_r;
      dev3_r  <= dev2_r;
      prod3_r <= PROD_W'(dev2_r) * PROD_W'(cfg_alpha);
    end
    if (en4) begin
      f4_r   <= f3_r;
      hp4_r  <= hp3_r;
      dev4_r <= dev3_r;
    end
  end

  // ema_r only moves when a new transaction enters the last stage
  assign out_valid          = v4_r;
  assign out_meas.frame     = f4_r;
  assign out_meas.have_prev = hp4_r;
  assign out_meas.dev       = dev4_r;
  assign out_meas.ema       = ema_r;

endmodule

`default_nettype wire
